// ----- sv/kbdq_pkg.sv -----
// ----------------------------------------------------------------------------
// kbdq_pkg: keyboard report queue framer package
// Shared types, codes and constants of the report queue and frame sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package kbdq_pkg;

  localparam int unsigned QueueDepthDef = 16;

  localparam logic [7:0] FrameHeader   = 8'hFF;
  localparam logic [7:0] KeyNumLock    = 8'h53;
  localparam logic [7:0] KeyCapsLock   = 8'h39;
  localparam logic [7:0] KeyScrollLock = 8'h47;
  localparam logic [7:0] LedNum        = 8'h01;
  localparam logic [7:0] LedCaps       = 8'h02;
  localparam logic [7:0] LedScroll     = 8'h04;
  localparam logic [7:0] LedMaskReset  = 8'hFF;

  typedef enum logic {
    OP_REPORT = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_FRAME = 2'd0,
    KIND_LED   = 2'd1,
    KIND_DROP  = 2'd2
  } kind_e;

  typedef struct packed {
    op_e        operation;
    logic [7:0] modifier_byte;
    logic [7:0] reserved_byte;
    logic [7:0] key_code_0;
    logic [7:0] key_code_1;
    logic [7:0] key_code_2;
    logic [7:0] key_code_3;
    logic [7:0] key_code_4;
    logic [7:0] key_code_5;
  } in_t;

  typedef struct packed {
    kind_e      result_kind;
    logic [7:0] data_byte;
    logic       last_of_run;
  } out_t;

  // report bytes packed with byte k in bits 8k+7..8k
  function automatic logic [63:0] report_word(in_t r);
    return {r.key_code_5, r.key_code_4, r.key_code_3, r.key_code_2,
            r.key_code_1, r.key_code_0, r.reserved_byte, r.modifier_byte};
  endfunction

  function automatic logic [7:0] led_scan(in_t r);
    logic [47:0] keys;
    logic [7:0]  leds;
    keys = {r.key_code_5, r.key_code_4, r.key_code_3,
            r.key_code_2, r.key_code_1, r.key_code_0};
    leds = 8'h00;
    for (int i = 0; i < 6; i++) begin
      if (keys[8*i +: 8] == KeyNumLock)    leds = leds | LedNum;
      if (keys[8*i +: 8] == KeyCapsLock)   leds = leds | LedCaps;
      if (keys[8*i +: 8] == KeyScrollLock) leds = leds | LedScroll;
    end
    return leds;
  endfunction

endpackage

`default_nettype wire

// ----- sv/kbdq_store.sv -----
// ----------------------------------------------------------------------------
// kbdq_store: report queue memory
// One write port and one registered read port, one 64-bit report per entry.
// ----------------------------------------------------------------------------
`default_nettype none

module kbdq_store #(
  parameter int unsigned QUEUE_DEPTH = kbdq_pkg::QueueDepthDef,
  parameter int unsigned AddrW       = $clog2(QUEUE_DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [63:0]      wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [63:0]      rdata_o
);

  logic [63:0] mem_q [QUEUE_DEPTH];
  logic [63:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- sv/kbdq_seq.sv -----
// ----------------------------------------------------------------------------
// kbdq_seq: queue control and frame sequencer
// Keeps the queue indices and LED mask, and walks one byte-shift/xor unit
// over a stored report to produce the header, eight bytes and checksum.
// ----------------------------------------------------------------------------
`default_nettype none

module kbdq_seq #(
  parameter int unsigned QUEUE_DEPTH = kbdq_pkg::QueueDepthDef,
  parameter int unsigned AddrW       = $clog2(QUEUE_DEPTH),
  parameter int unsigned CntW        = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire kbdq_pkg::in_t    in_i,
  output logic                  busy_o,
  output logic                  out_valid_o,
  output kbdq_pkg::out_t        out_o,
  output logic                  mem_we_o,
  output logic      [AddrW-1:0] mem_waddr_o,
  output logic      [63:0]      mem_wdata_o,
  output logic                  mem_re_o,
  output logic      [AddrW-1:0] mem_raddr_o,
  input  wire logic [63:0]      mem_rdata_i
);

  import kbdq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_NOTE = 5'b00010,
    S_HDR  = 5'b00100,
    S_BYTE = 5'b01000,
    S_CHK  = 5'b10000
  } state_e;

  localparam logic [CntW-1:0] DepthCnt = CntW'(QUEUE_DEPTH);

  state_e          state_q, state_d;
  logic [CntW-1:0] wr_idx_q, wr_idx_d;
  logic [AddrW-1:0] rd_idx_q, rd_idx_d;
  logic [7:0]      led_q, led_d;
  logic            drop_q, drop_d;
  logic            led_pend_q, led_pend_d;
  logic [2:0]      cnt_q, cnt_d;
  logic [63:0]     word_q, word_d;
  logic [7:0]      chk_q, chk_d;

  logic            full;
  logic [7:0]      led_new;
  logic [CntW-1:0] rd_next;

  assign full    = (wr_idx_q == DepthCnt);
  assign led_new = led_scan(in_i);
  assign rd_next = CntW'(rd_idx_q) + CntW'(1);

  assign busy_o      = (state_q != S_IDLE);
  assign mem_waddr_o = wr_idx_q[AddrW-1:0];
  assign mem_wdata_o = report_word(in_i);
  assign mem_raddr_o = rd_idx_q;

  always_comb begin
    state_d     = state_q;
    wr_idx_d    = wr_idx_q;
    rd_idx_d    = rd_idx_q;
    led_d       = led_q;
    drop_d      = drop_q;
    led_pend_d  = led_pend_q;
    cnt_d       = cnt_q;
    word_d      = word_q;
    chk_d       = chk_q;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    out_valid_o = 1'b0;
    out_o       = '{result_kind: KIND_FRAME, data_byte: 8'h00, last_of_run: 1'b0};

    unique case (state_q)
      S_IDLE: begin
        if (accept_i) begin
          if (in_i.operation == OP_REPORT) begin
            drop_d     = full;
            led_pend_d = (led_new != led_q);
            led_d      = led_new;
            if (!full) begin
              mem_we_o = 1'b1;
              wr_idx_d = wr_idx_q + CntW'(1);
            end
            if (full || (led_new != led_q)) begin
              state_d = S_NOTE;
            end
          end else if (wr_idx_q != '0) begin
            mem_re_o = 1'b1;
            state_d  = S_HDR;
          end
        end
      end
      S_NOTE: begin
        out_valid_o = 1'b1;
        if (drop_q) begin
          out_o.result_kind = KIND_DROP;
          out_o.last_of_run = !led_pend_q;
          drop_d            = 1'b0;
          if (!led_pend_q) begin
            state_d = S_IDLE;
          end
        end else begin
          out_o.result_kind = KIND_LED;
          out_o.data_byte   = led_q;
          out_o.last_of_run = 1'b1;
          led_pend_d        = 1'b0;
          state_d           = S_IDLE;
        end
      end
      S_HDR: begin
        // read data from the store lands during this cycle
        out_valid_o     = 1'b1;
        out_o.data_byte = FrameHeader;
        word_d          = mem_rdata_i;
        chk_d           = 8'h00;
        cnt_d           = 3'd0;
        state_d         = S_BYTE;
      end
      S_BYTE: begin
        out_valid_o     = 1'b1;
        out_o.data_byte = word_q[7:0];
        chk_d           = chk_q ^ word_q[7:0];
        word_d          = {8'h00, word_q[63:8]};
        cnt_d           = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        out_valid_o       = 1'b1;
        out_o.data_byte   = chk_q;
        out_o.last_of_run = 1'b1;
        // queue drained: both indices go back to the start
        if (rd_next >= wr_idx_q) begin
          rd_idx_d = '0;
          wr_idx_d = '0;
        end else begin
          rd_idx_d = rd_next[AddrW-1:0];
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      wr_idx_q   <= '0;
      rd_idx_q   <= '0;
      led_q      <= LedMaskReset;
      drop_q     <= 1'b0;
      led_pend_q <= 1'b0;
      cnt_q      <= 3'd0;
    end else begin
      state_q    <= state_d;
      wr_idx_q   <= wr_idx_d;
      rd_idx_q   <= rd_idx_d;
      led_q      <= led_d;
      drop_q     <= drop_d;
      led_pend_q <= led_pend_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    chk_q  <= chk_d;
  end

endmodule

`default_nettype wire

// ----- sv/keyboard_report_queue_framer.sv -----
// ----------------------------------------------------------------------------
// keyboard_report_queue_framer: keyboard report queue with serial framing
// A transaction is taken when start is high and busy is low. A keyboard
// report (operation 0) is appended to a QUEUE_DEPTH-entry queue, or dropped
// with a drop notice when the queue is full; its keycodes are scanned for
// num, caps and scroll lock and an LED mask result follows when the mask
// changes. A send tick (operation 1) on a non-empty queue emits the oldest
// report as a ten-byte frame: 0xFF header, the eight report bytes, then
// their xor checksum. Results appear on result_o for exactly one cycle,
// marked by result_valid_o; the receiver cannot stall, so no result waits.
// The first result is given in the cycle after the accept. A report runs
// through the accept and up to two notices (drop, then LED mask); a tick on
// a non-empty queue through the accept, header, eight bytes paced by the
// byte shift/xor unit and checksum; a tick on an empty queue is only accepted.
// Reset empties the queue and sets the stored LED mask to 0xFF, so the first
// report always yields an LED result; queue contents need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module keyboard_report_queue_framer #(
  parameter int unsigned QUEUE_DEPTH = kbdq_pkg::QueueDepthDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire kbdq_pkg::in_t  in_i,
  output logic                result_valid_o,
  output kbdq_pkg::out_t      result_o
);

  import kbdq_pkg::*;

  localparam int unsigned AddrW = $clog2(QUEUE_DEPTH);

  logic             accept;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [63:0]      mem_wdata;
  logic             mem_re;
  logic [AddrW-1:0] mem_raddr;
  logic [63:0]      mem_rdata;

  assign accept = start && !busy;

  kbdq_seq #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_i        (in_i),
    .busy_o      (busy),
    .out_valid_o (result_valid_o),
    .out_o       (result_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  kbdq_store #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire
